FILE: rtl/core/oriented_box_overlap_test_macros.svh
// assertion macros for the oriented box overlap test
`ifndef ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH

// same-cycle implication
`define OBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obt check failed");

// next-cycle implication
`define OBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obt check failed");

`endif

FILE: rtl/core/obt_pkg.sv
// shared types, constants and the quarter-wave sine generator
package obt_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 12;
    localparam int SCALE_BITS     = 16;
    localparam int TRIG_W         = 16;
    localparam int LATENCY        = 7;

    typedef struct packed {
        logic signed [TRIG_W-1:0] ca;
        logic signed [TRIG_W-1:0] sa;
        logic signed [TRIG_W-1:0] cb;
        logic signed [TRIG_W-1:0] sb;
    } trig_t;

    // quarter-wave sine in q1.14, evaluated at elaboration only
    function automatic logic [14:0] quarter_sine(longint unsigned q, int abits);
        longint unsigned one;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned r;
        one = 64'd1 << 30;
        x   = (q * 64'd1686629713) >> (abits - 2);
        x2  = (x * x) >> 30;
        t   = one;
        t   = one - (((x2 * t) >> 30) / 156);
        t   = one - (((x2 * t) >> 30) / 110);
        t   = one - (((x2 * t) >> 30) / 72);
        t   = one - (((x2 * t) >> 30) / 42);
        t   = one - (((x2 * t) >> 30) / 20);
        t   = one - (((x2 * t) >> 30) / 6);
        r   = (((x * t) >> 30) + (64'd1 << 15)) >> 16;
        if (r > 64'd16384)
        begin
            r = 64'd16384;
        end
        return r[14:0];
    endfunction

endpackage

FILE: rtl/core/obt_sine.sv
// sine lookup with registered quarter-wave table read
module obt_sine #(
    parameter int ANGLE_BITS = obt_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [ANGLE_BITS-1:0]                 angle,
    output logic signed [obt_pkg::TRIG_W-1:0]     value
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;

    logic [14:0]      rom [QUARTER+1];
    logic [1:0]       quad;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] idx;
    logic [14:0]      mag_reg;
    logic             neg_reg;

    for (genvar i = 0; i <= QUARTER; i++)
    begin : g_rom
        assign rom[i] = obt_pkg::quarter_sine(64'(i), ANGLE_BITS);
    end

    assign quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign rem  = IDX_W'(angle[ANGLE_BITS-3:0]);
    assign idx  = quad[0] ? (IDX_W'(QUARTER) - rem) : rem;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= rom[idx];
            neg_reg <= quad[1];
        end
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

FILE: rtl/core/obt_axis.sv
// one separating axis test: projections, extents and distance compare
module obt_axis #(
    parameter int COORD_BITS = obt_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [COORD_BITS:0]           dx,
    input  logic signed [COORD_BITS:0]           dy,
    input  logic signed [obt_pkg::TRIG_W-1:0]    ux,
    input  logic signed [obt_pkg::TRIG_W-1:0]    uy,
    input  obt_pkg::trig_t                       trig,
    input  logic [COORD_BITS-1:0]                aw,
    input  logic [COORD_BITS-1:0]                ah,
    input  logic [obt_pkg::SCALE_BITS-1:0]       asc,
    input  logic [COORD_BITS-1:0]                bw,
    input  logic [COORD_BITS-1:0]                bh,
    output logic                                 sep
);

    localparam int DW = COORD_BITS + 18;
    localparam int PW = 31;
    localparam int QW = 16;
    localparam int MW = COORD_BITS + QW;
    localparam int EW = COORD_BITS + 17;
    localparam int LW = COORD_BITS + 33;
    localparam int XW = COORD_BITS + 31;
    localparam int CW = COORD_BITS + 34;

    function automatic logic [QW-1:0] round_q14(logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        m = v[PW-1] ? PW'(-v) : PW'(v);
        r = (m + PW'(8192)) >> 14;
        return r[QW-1:0];
    endfunction

    // stage 2: dot products
    logic signed [DW-1:0] d_next, d_reg;
    logic signed [PW-1:0] a1_next, a2_next, b1_next, b2_next;
    logic signed [PW-1:0] a1_reg, a2_reg, b1_reg, b2_reg;
    logic [COORD_BITS-1:0] aw2_reg, ah2_reg, bw2_reg, bh2_reg;
    logic [obt_pkg::SCALE_BITS-1:0] asc2_reg, asc3_reg, asc4_reg;
    // stage 3: rounded projections times sizes
    logic [MW-1:0] wa_reg, ha_reg, wb_reg, hb_reg;
    logic [DW-1:0] dm_reg, dm4_reg;
    // stage 4: extents
    logic [EW-1:0] ea_reg, eb_reg;
    // stage 5: scaled lengths
    logic [LW-1:0] la_reg;
    logic [EW+11:0] lb_reg;
    logic [XW-1:0] dist_reg;
    logic sep_reg;

    logic signed [PW-1:0] uxp, uyp, cap, sap, cbp, sbp;
    logic signed [DW-1:0] dxe, dye, uxe, uye;

    always_comb
    begin
        uxp = PW'(ux);
        uyp = PW'(uy);
        cap = PW'(trig.ca);
        sap = PW'(trig.sa);
        cbp = PW'(trig.cb);
        sbp = PW'(trig.sb);
        dxe = DW'(dx);
        dye = DW'(dy);
        uxe = DW'(ux);
        uye = DW'(uy);
        d_next  = dxe * uxe + dye * uye;
        a1_next = cap * uxp + sap * uyp;
        a2_next = cap * uyp - sap * uxp;
        b1_next = cbp * uxp + sbp * uyp;
        b2_next = cbp * uyp - sbp * uxp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
            aw2_reg  <= aw;
            ah2_reg  <= ah;
            bw2_reg  <= bw;
            bh2_reg  <= bh;
            asc2_reg <= asc;

            wa_reg   <= MW'(aw2_reg) * MW'(round_q14(a1_reg));
            ha_reg   <= MW'(ah2_reg) * MW'(round_q14(a2_reg));
            wb_reg   <= MW'(bw2_reg) * MW'(round_q14(b1_reg));
            hb_reg   <= MW'(bh2_reg) * MW'(round_q14(b2_reg));
            dm_reg   <= d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
            asc3_reg <= asc2_reg;

            ea_reg   <= EW'(wa_reg) + EW'(ha_reg);
            eb_reg   <= EW'(wb_reg) + EW'(hb_reg);
            dm4_reg  <= dm_reg;
            asc4_reg <= asc3_reg;

            la_reg   <= LW'(asc4_reg) * LW'(ea_reg);
            lb_reg   <= {eb_reg, 12'd0};
            dist_reg <= {dm4_reg, 13'd0};

            sep_reg  <= CW'(dist_reg) >= (CW'(la_reg) + CW'(lb_reg));
        end
    end

    assign sep = sep_reg;

endmodule

FILE: rtl/core/oriented_box_overlap_test.sv
// top level of the oriented box overlap test
// usage: one item on s_* carries two boxes (centre, size, angle, plus a scale
// for box a); one item on m_* carries the overlap flag for that pair.
// an item is taken when tvalid and tready are both high; results leave in
// the same order as items enter.
// throughput: one item per cycle while the output is not stalled; the pipeline
// has 7 register stages, with four registered quarter-wave sine tables of
// 2^(ANGLE_BITS-2)+1 entries in the first stage and one separating-axis unit
// per box edge normal after it.
// a stalled output freezes the whole pipeline: s_tready follows
// (!m_tvalid || m_tready), so nothing is dropped or repeated.
// zero width, height or scale gives overlap = 0; touching counts as apart.
// reset clears all valid bits; no item is in flight after reset and the
// block accepts items in the first cycle after reset is released.
`include "oriented_box_overlap_test_macros.svh"

module oriented_box_overlap_test #(
    parameter int COORD_BITS = obt_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = obt_pkg::ANGLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // a_center_x, a_center_y, a_width, a_height, a_angle, a_scale,
    // b_center_x, b_center_y, b_width, b_height, b_angle
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((8*COORD_BITS+2*ANGLE_BITS+obt_pkg::SCALE_BITS+7)/8)*8-1:0] s_tdata,
    // overlap
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [7:0]                               m_tdata
);

    localparam int LAT  = obt_pkg::LATENCY;
    localparam int CB   = COORD_BITS;
    localparam int AB   = ANGLE_BITS;
    localparam int SB   = obt_pkg::SCALE_BITS;
    localparam int O_AA = 4 * CB;
    localparam int O_AS = O_AA + AB;
    localparam int O_B  = O_AS + SB;
    localparam int O_BA = O_B + 4 * CB;

    logic signed [CB-1:0] a_center_x, a_center_y, b_center_x, b_center_y;
    logic [CB-1:0] a_width, a_height, b_width, b_height;
    logic [AB-1:0] a_angle, b_angle;
    logic [SB-1:0] a_scale;

    assign a_center_x = s_tdata[CB-1:0];
    assign a_center_y = s_tdata[2*CB-1:CB];
    assign a_width    = s_tdata[3*CB-1:2*CB];
    assign a_height   = s_tdata[4*CB-1:3*CB];
    assign a_angle    = s_tdata[O_AA+AB-1:O_AA];
    assign a_scale    = s_tdata[O_AS+SB-1:O_AS];
    assign b_center_x = s_tdata[O_B+CB-1:O_B];
    assign b_center_y = s_tdata[O_B+2*CB-1:O_B+CB];
    assign b_width    = s_tdata[O_B+3*CB-1:O_B+2*CB];
    assign b_height   = s_tdata[O_B+4*CB-1:O_B+3*CB];
    assign b_angle    = s_tdata[O_BA+AB-1:O_BA];

    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic adv;
    logic [LAT-1:0] valid_reg;
    logic [LAT-2:0] deg_reg;
    logic deg_next;
    logic signed [CB:0] dx_reg, dy_reg;
    logic [CB-1:0] aw_reg, ah_reg, bw_reg, bh_reg;
    logic [SB-1:0] asc_reg;
    logic overlap_reg;
    obt_pkg::trig_t trig;
    logic signed [obt_pkg::TRIG_W-1:0] ux [4];
    logic signed [obt_pkg::TRIG_W-1:0] uy [4];
    logic [3:0] sep;

    assign adv      = !valid_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign deg_next = (a_width == '0) || (a_height == '0) || (a_scale == '0)
                   || (b_width == '0) || (b_height == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg     <= {deg_reg[LAT-3:0], deg_next};
            dx_reg      <= (CB+1)'(b_center_x) - (CB+1)'(a_center_x);
            dy_reg      <= (CB+1)'(b_center_y) - (CB+1)'(a_center_y);
            aw_reg      <= a_width;
            ah_reg      <= a_height;
            bw_reg      <= b_width;
            bh_reg      <= b_height;
            asc_reg     <= a_scale;
            overlap_reg <= !deg_reg[LAT-2] && (sep == 4'd0);
        end
    end

    obt_sine #(.ANGLE_BITS(AB)) u_cos_a (
        .clk(clk), .en(adv), .angle(a_angle + QUARTER), .value(trig.ca));
    obt_sine #(.ANGLE_BITS(AB)) u_sin_a (
        .clk(clk), .en(adv), .angle(a_angle), .value(trig.sa));
    obt_sine #(.ANGLE_BITS(AB)) u_cos_b (
        .clk(clk), .en(adv), .angle(b_angle + QUARTER), .value(trig.cb));
    obt_sine #(.ANGLE_BITS(AB)) u_sin_b (
        .clk(clk), .en(adv), .angle(b_angle), .value(trig.sb));

    // edge normals: e2 of a, e1 of a, e2 of b, e1 of b
    assign ux[0] = -trig.sa;
    assign uy[0] = trig.ca;
    assign ux[1] = trig.ca;
    assign uy[1] = trig.sa;
    assign ux[2] = -trig.sb;
    assign uy[2] = trig.cb;
    assign ux[3] = trig.cb;
    assign uy[3] = trig.sb;

    for (genvar i = 0; i < 4; i++)
    begin : g_axis
        obt_axis #(.COORD_BITS(CB)) u_axis (
            .clk (clk),
            .en  (adv),
            .dx  (dx_reg),
            .dy  (dy_reg),
            .ux  (ux[i]),
            .uy  (uy[i]),
            .trig(trig),
            .aw  (aw_reg),
            .ah  (ah_reg),
            .asc (asc_reg),
            .bw  (bw_reg),
            .bh  (bh_reg),
            .sep (sep[i])
        );
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {7'd0, overlap_reg};

    `OBT_ASSERT_NEXT(a_stall_holds_valid, !adv, valid_reg == $past(valid_reg))
    `OBT_ASSERT_NEXT(a_degenerate_no_overlap, adv && deg_reg[LAT-2], !overlap_reg)
    `OBT_ASSERT_NEXT(a_zero_width_marks_degenerate, s_tvalid && s_tready && a_width == '0, deg_reg[0])

endmodule

FILE: dv/oriented_box_overlap_test_tb.sv
// self-checking testbench for the oriented box overlap test
module oriented_box_overlap_test_tb;

    localparam int CB = obt_pkg::COORD_BITS_DEF;
    localparam int AB = obt_pkg::ANGLE_BITS_DEF;
    localparam int SB = obt_pkg::SCALE_BITS;
    localparam int DW = ((8*CB+2*AB+SB+7)/8)*8;
    localparam int QTR = 1 << (AB-2);
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [AB-1:0] b_angle;
        logic [CB-1:0] b_height;
        logic [CB-1:0] b_width;
        logic [CB-1:0] b_center_y;
        logic [CB-1:0] b_center_x;
        logic [SB-1:0] a_scale;
        logic [AB-1:0] a_angle;
        logic [CB-1:0] a_height;
        logic [CB-1:0] a_width;
        logic [CB-1:0] a_center_y;
        logic [CB-1:0] a_center_x;
    } box_pair_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [DW-1:0] s_tdata;   // a_center_x, a_center_y, a_width, a_height, a_angle, a_scale,
                              // b_center_x, b_center_y, b_width, b_height, b_angle
    logic m_tvalid;
    logic m_tready;
    logic [7:0] m_tdata;      // overlap

    logic expected_overlap_q[$];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    int errors;
    int pairs_sent;
    int results_seen;
    int overlaps_seen;
    longint cycles;
    longint unsigned sine_tab[0:QTR];

    oriented_box_overlap_test u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint unsigned quarter_wave(longint unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned r;
        int divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        x = (q * 64'd1686629713) >> (AB-2);
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
        begin
            t = (64'd1 << 30) - (((x2 * t) >> 30) / divs[i]);
        end
        r = (((x * t) >> 30) + (64'd1 << 15)) >> 16;
        return (r > 64'd16384) ? 64'd16384 : r;
    endfunction

    function automatic longint sin_q14(longint unsigned ang);
        longint unsigned a;
        longint unsigned rem;
        longint unsigned m;
        int quad;
        a = ang % (1 << AB);
        quad = int'(a >> (AB-2)) & 3;
        rem = a % QTR;
        m = (quad & 1) ? sine_tab[QTR - rem] : sine_tab[rem];
        return (quad & 2) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned span(longint c, longint s, longint unsigned w,
                                             longint unsigned h, longint ux, longint uy);
        longint unsigned p1;
        longint unsigned p2;
        p1 = (abs64(c*ux + s*uy) + 8192) >> 14;
        p2 = (abs64(-s*ux + c*uy) + 8192) >> 14;
        return w*p1 + h*p2;
    endfunction

    function automatic logic boxes_overlap(box_pair_t p);
        longint ca, sa, cb, sb, dx, dy;
        longint ux[4];
        longint uy[4];
        longint unsigned sep_dist, la, lb;
        if (p.a_width == 0 || p.a_height == 0 || p.a_scale == 0 ||
            p.b_width == 0 || p.b_height == 0)
        begin
            return 1'b0;
        end
        ca = sin_q14(p.a_angle + QTR);
        sa = sin_q14(p.a_angle);
        cb = sin_q14(p.b_angle + QTR);
        sb = sin_q14(p.b_angle);
        ux = '{-sa, ca, -sb, cb};
        uy = '{ca, sa, cb, sb};
        dx = longint'($signed(p.b_center_x)) - longint'($signed(p.a_center_x));
        dy = longint'($signed(p.b_center_y)) - longint'($signed(p.a_center_y));
        for (int i = 0; i < 4; i++)
        begin
            sep_dist = abs64(dx*ux[i] + dy*uy[i]) << 13;
            la = longint'(p.a_scale) * span(ca, sa, p.a_width, p.a_height, ux[i], uy[i]);
            lb = span(cb, sb, p.b_width, p.b_height, ux[i], uy[i]) << 12;
            if (sep_dist >= la + lb)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_pair(box_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DW'(p);
        expected_overlap_q = {expected_overlap_q, boxes_overlap(p)};
        pairs_sent++;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic box_pair_t random_pair(int sz_max, int spread);
        box_pair_t p;
        p = box_pair_t'(DW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        p.a_width = CB'($urandom_range(sz_max, 1));
        p.a_height = CB'($urandom_range(sz_max, 1));
        p.b_width = CB'($urandom_range(sz_max, 1));
        p.b_height = CB'($urandom_range(sz_max, 1));
        p.a_scale = SB'($urandom_range(8192, 1024));
        p.a_center_x = CB'($urandom_range(2*spread) - spread);
        p.a_center_y = CB'($urandom_range(2*spread) - spread);
        p.b_center_x = p.a_center_x + CB'($urandom_range(2*spread) - spread);
        p.b_center_y = p.a_center_y + CB'($urandom_range(2*spread) - spread);
        return p;
    endfunction

    task automatic test_directed();
        box_pair_t p;
        p = '0;
        p.a_width = 16'd160; p.a_height = 16'd80; p.a_scale = 16'h1000;
        p.b_width = 16'd160; p.b_height = 16'd80;
        send_pair(p);                               // coincident
        p.b_center_x = 16'd160; send_pair(p);       // touching on x
        p.b_center_x = 16'd159; send_pair(p);
        p.b_angle = 12'd512; p.b_center_x = 16'd200; send_pair(p);
        p.a_angle = 12'd1024; p.b_angle = 12'd3072; send_pair(p);
        p.a_angle = 12'd4095; send_pair(p);
        p.a_width = 0; send_pair(p);                // degenerate boxes
        p.a_width = 16'd160; p.a_scale = 0; send_pair(p);
        p.a_scale = 16'h1000; p.b_height = 0; send_pair(p);
        p.b_height = 16'd80; p.b_width = 0; send_pair(p);
        p.b_width = 16'd80; p.a_height = 0; send_pair(p);
        p = '1;                                     // all ones
        send_pair(p);
        p.a_center_x = 16'h8000; p.a_center_y = 16'h8000;
        p.b_center_x = 16'h7fff; p.b_center_y = 16'h7fff;
        send_pair(p);
        p.a_scale = 16'hffff; p.a_angle = 12'd2048; p.b_angle = 12'd1;
        p.b_width = 16'd1; p.b_height = 16'd1; p.a_width = 16'd1; p.a_height = 16'd1;
        send_pair(p);
        p.a_center_x = 0; p.a_center_y = 0; p.b_center_x = 0; p.b_center_y = 0;
        send_pair(p);
    endtask

    task automatic test_random(int n);
        box_pair_t p;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: p = box_pair_t'(DW'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom}));
                1: p = random_pair(65535, 32767);
                default: p = random_pair(800, 600);
            endcase
            send_pair(p);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(40);
        stop_sending();
        wait (hold_off == 0);
        @(posedge clk);
    endtask

    task automatic drain();
        stop_sending();
        while (expected_overlap_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2*obt_pkg::LATENCY) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_overlap_q.size() == 0)
                begin
                    $error("overlap: unexpected item, actual %0d", m_tdata[0]);
                    errors++;
                end
                else
                begin
                    logic e;
                    e = expected_overlap_q.pop_front();
                    overlaps_seen += m_tdata[0];
                    if (m_tdata[0] !== e)
                    begin
                        $error("overlap: expected %0d actual %0d", e, m_tdata[0]);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        errors = 0; pairs_sent = 0; results_seen = 0; overlaps_seen = 0;
        cycles = 0; hold_off = 0;
        send_idle_pct = 22; recv_idle_pct = 52;
        for (int q = 0; q <= QTR; q++)
        begin
            sine_tab[q] = quarter_wave(q);
        end
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        send_idle_pct = 52; recv_idle_pct = 22;
        test_backpressure();
        test_random(400);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(400);
        drain();
        $display("%0d box pairs sent, %0d results checked, %0d overlapping",
                 pairs_sent, results_seen, overlaps_seen);
        if (errors == 0 && expected_overlap_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/obt_pkg.sv
rtl/core/obt_sine.sv
rtl/core/obt_axis.sv
rtl/core/oriented_box_overlap_test.sv
dv/oriented_box_overlap_test_tb.sv
